>>> hdl/bdt_pkg.sv
package bdt_pkg;

    // Input item modes
    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_BYTE  = 2'd1,
        MODE_LINK  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAX_PER_CMD = 2'd0,
        CFG_CODE_UPPER  = 2'd1,
        CFG_CODE_LOWER  = 2'd2,
        CFG_CODE_BOTH   = 2'd3
    } cfg_idx_t;

    // Register reset values
    localparam logic [6:0] MAX_PER_CMD_RST = 7'd60;
    localparam logic [7:0] CODE_UPPER_RST  = 8'h45;
    localparam logic [7:0] CODE_LOWER_RST  = 8'h55;
    localparam logic [7:0] CODE_BOTH_RST   = 8'h56;

    // Status classes
    localparam logic [3:0] ST_GOOD        = 4'd0;
    localparam logic [3:0] ST_NORMAL_STOP = 4'd1;
    localparam logic [3:0] ST_REQUEST     = 4'd8;
    localparam logic [3:0] ST_CONNECTION  = 4'd11;
    localparam logic [3:0] ST_UNKNOWN     = 4'd12;

    // Frame error codes
    localparam logic [2:0] FERR_NONE       = 3'd0;
    localparam logic [2:0] FERR_BAD_LEN    = 3'd1;
    localparam logic [2:0] FERR_UNEXP_CMD  = 3'd2;
    localparam logic [2:0] FERR_NON_DIGIT  = 3'd3;
    localparam logic [2:0] FERR_NOT_ACTIVE = 3'd4;
    localparam logic [2:0] FERR_EMPTY_REQ  = 3'd5;

    // Command data lengths
    localparam logic [2:0] DLEN_NONE   = 3'd0;
    localparam logic [2:0] DLEN_SINGLE = 3'd2;
    localparam logic [2:0] DLEN_DOUBLE = 3'd4;

    // Frame layout
    localparam logic [5:0] SINGLE_FRAME_LEN = 6'd10;
    localparam logic [5:0] DOUBLE_FRAME_LEN = 6'd17;
    localparam int         CAPT_BYTES       = 16;   // highest position read is 15
    localparam logic [5:0] POS_MAX          = 6'd63;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] STAT_LO    = 8'h30;
    localparam logic [7:0] STAT_HI    = 8'h4f;

    // Status byte 0x30..0x4f to status class
    localparam logic [3:0] STATUS_MAP [32] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd3, 4'd3, 4'd5,
        4'd6, 4'd12, 4'd7, 4'd8, 4'd7, 4'd7, 4'd12, 4'd5,
        4'd6, 4'd5, 4'd3, 4'd9, 4'd10, 4'd5, 4'd5, 4'd9,
        4'd3, 4'd5, 4'd5, 4'd12, 4'd3, 4'd12, 4'd3, 4'd12
    };

    typedef logic [CAPT_BYTES-1:0][7:0] capt_bytes_t;

    // Frame view handed from the capture stage to the decoder
    typedef struct packed {
        capt_bytes_t bytes;
        logic [5:0]  len;
    } frame_t;

    // One result item
    typedef struct packed {
        logic        cmd_valid;
        logic [7:0]  cmd_code;
        logic [15:0] cmd_first_digits;
        logic [15:0] cmd_second_digits;
        logic [2:0]  cmd_data_len;
        logic        done_res;
        logic [3:0]  status;
        logic [11:0] upper_dispensed;
        logic [11:0] lower_dispensed;
        logic [11:0] upper_rejected;
        logic [11:0] lower_rejected;
        logic [2:0]  frame_error;
    } res_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= ASCII_ZERO) && (b <= ASCII_NINE);
    endfunction

    // Two ASCII digits to a count 0..99 (digits already checked)
    function automatic logic [6:0] ascii_pair(input logic [7:0] hi, input logic [7:0] lo);
        logic [6:0] t;
        t = 7'(hi[3:0]) * 7'd10;
        return t + 7'(lo[3:0]);
    endfunction

    function automatic logic [3:0] map_status(input logic [7:0] b);
        logic [7:0] idx;
        idx = b - STAT_LO;
        if ((b >= STAT_LO) && (b <= STAT_HI))
            return STATUS_MAP[idx[4:0]];
        return ST_UNKNOWN;
    endfunction

    // Count 0..99 to ASCII tens/units; n*103>>10 is n/10 over this range
    function automatic logic [15:0] enc_count(input logic [6:0] n);
        logic [13:0] p;
        logic [3:0]  tens;
        logic [6:0]  tt;
        logic [6:0]  u;
        p    = 14'(n) * 14'd103;
        tens = p[13:10];
        tt   = 7'(tens) * 7'd10;
        u    = n - tt;
        return {4'h3, tens, 4'h3, u[3:0]};
    endfunction

endpackage

>>> hdl/bdt_in_if.sv
interface bdt_in_if
    import bdt_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [11:0] request_upper;
    logic [11:0] request_lower;
    logic [7:0]  data_byte;
    logic        last_byte;

    modport source (output valid, mode, request_upper, request_lower, data_byte, last_byte,
                    input ready);
    modport sink   (input valid, mode, request_upper, request_lower, data_byte, last_byte,
                    output ready);
endinterface

>>> hdl/bdt_out_if.sv
interface bdt_out_if
    import bdt_pkg::*;
();
    logic        valid;
    logic        ready;
    logic        cmd_valid;
    logic [7:0]  cmd_code;
    logic [15:0] cmd_first_digits;
    logic [15:0] cmd_second_digits;
    logic [2:0]  cmd_data_len;
    logic        done_res;
    logic [3:0]  status;
    logic [11:0] upper_dispensed;
    logic [11:0] lower_dispensed;
    logic [11:0] upper_rejected;
    logic [11:0] lower_rejected;
    logic [2:0]  frame_error;

    modport source (output valid, cmd_valid, cmd_code, cmd_first_digits, cmd_second_digits,
                           cmd_data_len, done_res, status, upper_dispensed, lower_dispensed,
                           upper_rejected, lower_rejected, frame_error,
                    input  ready);
    modport sink   (input  valid, cmd_valid, cmd_code, cmd_first_digits, cmd_second_digits,
                           cmd_data_len, done_res, status, upper_dispensed, lower_dispensed,
                           upper_rejected, lower_rejected, frame_error,
                    output ready);
endinterface

>>> hdl/bdt_frame_capture.sv
module bdt_frame_capture
    import bdt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  logic       clear,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output frame_t     frame
);

    logic [5:0]  pos_reg;
    logic [5:0]  pos_next;
    capt_bytes_t bytes_reg;

    // Byte position, saturating; back to zero at frame end or on clear
    always_comb
    begin
        pos_next = pos_reg;
        if (clear)
        begin
            pos_next = '0;
        end
        else if (wr_en)
        begin
            if (last_byte)
                pos_next = '0;
            else if (pos_reg != POS_MAX)
                pos_next = pos_reg + 6'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

    // Only the leading bytes are ever decoded, so only those are kept
    always_ff @(posedge clk)
    begin
        if (wr_en && (pos_reg < 6'(CAPT_BYTES)))
            bytes_reg[pos_reg[3:0]] <= data_byte;
    end

    // Frame view including the byte arriving now
    always_comb
    begin
        for (int k = 0; k < CAPT_BYTES; k++)
        begin
            if (pos_reg == 6'(k))
                frame.bytes[k] = data_byte;
            else
                frame.bytes[k] = bytes_reg[k];
        end
        frame.len = (pos_reg == POS_MAX) ? POS_MAX : pos_reg + 6'd1;
    end

endmodule

>>> hdl/bill_dispense_transaction_top.sv
// Channel  Dir  Handshake        Payload
// din      in   valid / ready    mode, request_upper, request_lower, data_byte, last_byte
// dout     out  valid / ready    command fields, done_res, status, counters, frame_error
// cfg      in   cfg_we           cfg_index, cfg_data (write only)
//
// One item per cycle sustained while the result register is not stalled; an item
// passes through the input register, then its result through the result register to dout.
// The decode of a finished frame, counter update and next command encode sit
// in the single logic stage between those two registers.
// An item with a result waits in the input register while the result register
// is stalled; din.ready then drops. Items without a result never wait.
// rst_n clears all counters, flags and the configuration to its defaults.
module bill_dispense_transaction_top
    import bdt_pkg::*;
#(
    parameter int COUNT_WIDTH = 12
)
(
    input  logic       clk,
    input  logic       rst_n,
    bdt_in_if.sink     din,
    bdt_out_if.source  dout,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int CW = COUNT_WIDTH;
    localparam logic [CW:0] CNT_MAX = {1'b0, {CW{1'b1}}};

    // Configuration
    logic [6:0] max_per_cmd_reg;
    logic [7:0] code_upper_reg;
    logic [7:0] code_lower_reg;
    logic [7:0] code_both_reg;

    // Input register
    logic        s1_valid_reg;
    mode_t       s1_mode_reg;
    logic [11:0] s1_req_u_reg;
    logic [11:0] s1_req_l_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;

    // Operation state
    logic [CW-1:0] rem_u_reg, rem_u_next;
    logic [CW-1:0] rem_l_reg, rem_l_next;
    logic [CW-1:0] disp_u_reg, disp_u_next;
    logic [CW-1:0] disp_l_reg, disp_l_next;
    logic [CW-1:0] rej_u_reg, rej_u_next;
    logic [CW-1:0] rej_l_reg, rej_l_next;
    logic          failed_reg, failed_next;

    // Result register
    logic out_valid_reg;
    res_t out_reg;
    res_t res;

    logic s1_has_res;
    logic s1_adv;
    logic active;

    frame_t frame;
    logic   capt_wr;
    logic   capt_clr;

    logic       fin;
    logic       iss;
    logic       frame_ok;
    logic [3:0] st;
    logic [2:0] ferr;

    logic       up_match;
    logic       lo_match;
    logic       single_dig_ok;
    logic       double_dig_ok;
    logic [6:0] cnt_a, cnt_b, cnt_c, cnt_d;

    logic [6:0]    cap;
    logic [CW-1:0] cap_w;
    logic [6:0]    n_u, n_l;

    // Pipeline control
    assign s1_has_res = s1_valid_reg && ((s1_mode_reg == MODE_START) ||
                                         (s1_mode_reg == MODE_LINK) ||
                                         ((s1_mode_reg == MODE_BYTE) && s1_last_reg));
    assign s1_adv    = s1_valid_reg && (!s1_has_res || !out_valid_reg || dout.ready);
    assign din.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (din.ready)
            s1_valid_reg <= din.valid;
    end

    always_ff @(posedge clk)
    begin
        if (din.ready && din.valid)
        begin
            s1_mode_reg  <= mode_t'(din.mode);
            s1_req_u_reg <= din.request_upper;
            s1_req_l_reg <= din.request_lower;
            s1_byte_reg  <= din.data_byte;
            s1_last_reg  <= din.last_byte;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_per_cmd_reg <= MAX_PER_CMD_RST;
            code_upper_reg  <= CODE_UPPER_RST;
            code_lower_reg  <= CODE_LOWER_RST;
            code_both_reg   <= CODE_BOTH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MAX_PER_CMD: max_per_cmd_reg <= cfg_data[6:0];
                CFG_CODE_UPPER:  code_upper_reg  <= cfg_data;
                CFG_CODE_LOWER:  code_lower_reg  <= cfg_data;
                CFG_CODE_BOTH:   code_both_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Response frame capture
    assign capt_wr  = s1_adv && (s1_mode_reg == MODE_BYTE);
    assign capt_clr = s1_adv && ((s1_mode_reg == MODE_START) || (s1_mode_reg == MODE_LINK));

    bdt_frame_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (capt_wr),
        .clear     (capt_clr),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .frame     (frame)
    );

    // Frame field checks and counts
    assign active   = !failed_reg && ((rem_u_reg != '0) || (rem_l_reg != '0));
    assign up_match = (frame.bytes[0] == code_upper_reg);
    assign lo_match = (frame.bytes[0] == code_lower_reg);
    assign single_dig_ok = is_digit(frame.bytes[3]) && is_digit(frame.bytes[4]) &&
                           is_digit(frame.bytes[7]) && is_digit(frame.bytes[8]);
    assign double_dig_ok = single_dig_ok &&
                           is_digit(frame.bytes[12]) && is_digit(frame.bytes[13]) &&
                           is_digit(frame.bytes[14]) && is_digit(frame.bytes[15]);
    assign cnt_a = ascii_pair(frame.bytes[3], frame.bytes[4]);
    assign cnt_b = ascii_pair(frame.bytes[7], frame.bytes[8]);
    assign cnt_c = ascii_pair(frame.bytes[12], frame.bytes[13]);
    assign cnt_d = ascii_pair(frame.bytes[14], frame.bytes[15]);

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [6:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + (CW+1)'(b);
        return (s > CNT_MAX) ? CNT_MAX[CW-1:0] : s[CW-1:0];
    endfunction

    function automatic logic [CW-1:0] sat_sub(input logic [CW-1:0] a, input logic [6:0] b);
        return (a > CW'(b)) ? a - CW'(b) : '0;
    endfunction

    // Item decode and state update
    always_comb
    begin
        rem_u_next  = rem_u_reg;
        rem_l_next  = rem_l_reg;
        disp_u_next = disp_u_reg;
        disp_l_next = disp_l_reg;
        rej_u_next  = rej_u_reg;
        rej_l_next  = rej_l_reg;
        failed_next = failed_reg;
        fin         = 1'b0;
        iss         = 1'b0;
        frame_ok    = 1'b0;
        st          = ST_GOOD;
        ferr        = FERR_NONE;

        unique case (s1_mode_reg)
            MODE_START:
            begin
                rem_u_next  = CW'(s1_req_u_reg);
                rem_l_next  = CW'(s1_req_l_reg);
                disp_u_next = '0;
                disp_l_next = '0;
                rej_u_next  = '0;
                rej_l_next  = '0;
                failed_next = 1'b0;
                if ((rem_u_next == '0) && (rem_l_next == '0))
                begin
                    fin  = 1'b1;
                    st   = ST_REQUEST;
                    ferr = FERR_EMPTY_REQ;
                end
                else
                begin
                    iss = 1'b1;
                end
            end
            MODE_BYTE:
            begin
                if (s1_last_reg)
                begin
                    if (!active)
                    begin
                        fin  = 1'b1;
                        st   = ST_UNKNOWN;
                        ferr = FERR_NOT_ACTIVE;
                    end
                    else if (frame.len == SINGLE_FRAME_LEN)
                    begin
                        if (!up_match && !lo_match)
                            ferr = FERR_UNEXP_CMD;
                        else if (!single_dig_ok)
                            ferr = FERR_NON_DIGIT;
                        else
                        begin
                            frame_ok = 1'b1;
                            if (up_match)
                            begin
                                rem_u_next  = sat_sub(rem_u_reg, cnt_a);
                                disp_u_next = sat_add(disp_u_reg, cnt_a);
                                rej_u_next  = sat_add(rej_u_reg, cnt_b);
                            end
                            else
                            begin
                                rem_l_next  = sat_sub(rem_l_reg, cnt_a);
                                disp_l_next = sat_add(disp_l_reg, cnt_a);
                                rej_l_next  = sat_add(rej_l_reg, cnt_b);
                            end
                            st = map_status(frame.bytes[5]);
                        end
                    end
                    else if (frame.len == DOUBLE_FRAME_LEN)
                    begin
                        if (frame.bytes[0] != code_both_reg)
                            ferr = FERR_UNEXP_CMD;
                        else if (!double_dig_ok)
                            ferr = FERR_NON_DIGIT;
                        else
                        begin
                            frame_ok    = 1'b1;
                            rem_u_next  = sat_sub(rem_u_reg, cnt_a);
                            disp_u_next = sat_add(disp_u_reg, cnt_a);
                            rej_u_next  = sat_add(rej_u_reg, cnt_c);
                            rem_l_next  = sat_sub(rem_l_reg, cnt_b);
                            disp_l_next = sat_add(disp_l_reg, cnt_b);
                            rej_l_next  = sat_add(rej_l_reg, cnt_d);
                            st = map_status(frame.bytes[9]);
                        end
                    end
                    else
                    begin
                        ferr = FERR_BAD_LEN;
                    end

                    // Rejected frame: report and stop the operation
                    if (active && !frame_ok)
                    begin
                        fin         = 1'b1;
                        st          = ST_UNKNOWN;
                        failed_next = 1'b1;
                    end

                    // Accepted frame: stop, finish or send the next command
                    if (frame_ok)
                    begin
                        if ((st != ST_GOOD) && (st != ST_NORMAL_STOP))
                        begin
                            failed_next = 1'b1;
                            fin         = 1'b1;
                        end
                        else if ((rem_u_next == '0) && (rem_l_next == '0))
                            fin = 1'b1;
                        else
                            iss = 1'b1;
                    end
                end
            end
            MODE_LINK:
            begin
                failed_next = 1'b1;
                fin         = 1'b1;
                st          = ST_CONNECTION;
                ferr        = active ? FERR_NONE : FERR_NOT_ACTIVE;
            end
            default: ;
        endcase
    end

    // Per-command cap, clamped to 1..99
    always_comb
    begin
        if (max_per_cmd_reg == 7'd0)
            cap = 7'd1;
        else if (max_per_cmd_reg > 7'd99)
            cap = 7'd99;
        else
            cap = max_per_cmd_reg;
    end

    assign cap_w = CW'(cap);
    assign n_u   = (rem_u_next > cap_w) ? cap : rem_u_next[6:0];
    assign n_l   = (rem_l_next > cap_w) ? cap : rem_l_next[6:0];

    // Result item
    always_comb
    begin
        res                 = '0;
        res.upper_dispensed = 12'(disp_u_next);
        res.lower_dispensed = 12'(disp_l_next);
        res.upper_rejected  = 12'(rej_u_next);
        res.lower_rejected  = 12'(rej_l_next);
        if (fin)
        begin
            res.done_res    = 1'b1;
            res.status      = st;
            res.frame_error = ferr;
        end
        if (iss)
        begin
            res.cmd_valid = 1'b1;
            res.status    = st;
            if ((rem_u_next != '0) && (rem_l_next != '0))
            begin
                res.cmd_code          = code_both_reg;
                res.cmd_first_digits  = enc_count(n_u);
                res.cmd_second_digits = enc_count(n_l);
                res.cmd_data_len      = DLEN_DOUBLE;
            end
            else if (rem_u_next != '0)
            begin
                res.cmd_code         = code_upper_reg;
                res.cmd_first_digits = enc_count(n_u);
                res.cmd_data_len     = DLEN_SINGLE;
            end
            else
            begin
                res.cmd_code         = code_lower_reg;
                res.cmd_first_digits = enc_count(n_l);
                res.cmd_data_len     = DLEN_SINGLE;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_u_reg  <= '0;
            rem_l_reg  <= '0;
            disp_u_reg <= '0;
            disp_l_reg <= '0;
            rej_u_reg  <= '0;
            rej_l_reg  <= '0;
            failed_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            rem_u_reg  <= rem_u_next;
            rem_l_reg  <= rem_l_next;
            disp_u_reg <= disp_u_next;
            disp_l_reg <= disp_l_next;
            rej_u_reg  <= rej_u_next;
            rej_l_reg  <= rej_l_next;
            failed_reg <= failed_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv && s1_has_res)
            out_valid_reg <= 1'b1;
        else if (dout.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_has_res)
            out_reg <= res;
    end

    assign dout.valid             = out_valid_reg;
    assign dout.cmd_valid         = out_reg.cmd_valid;
    assign dout.cmd_code          = out_reg.cmd_code;
    assign dout.cmd_first_digits  = out_reg.cmd_first_digits;
    assign dout.cmd_second_digits = out_reg.cmd_second_digits;
    assign dout.cmd_data_len      = out_reg.cmd_data_len;
    assign dout.done_res          = out_reg.done_res;
    assign dout.status            = out_reg.status;
    assign dout.upper_dispensed   = out_reg.upper_dispensed;
    assign dout.lower_dispensed   = out_reg.lower_dispensed;
    assign dout.upper_rejected    = out_reg.upper_rejected;
    assign dout.lower_rejected    = out_reg.lower_rejected;
    assign dout.frame_error       = out_reg.frame_error;

`ifndef SYNTHESIS
    // A result is either a command or a completion, never both
    a_cmd_xor_done: assert property (@(posedge clk) disable iff (!rst_n)
        dout.valid |-> !(dout.cmd_valid && dout.done_res))
        else $error("result is both command and completion");

    // Every item that yields a result lands in the result register
    a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_has_res) |=> out_valid_reg)
        else $error("result lost");

    // A link failure always leaves the operation failed
    a_link_fails: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (s1_mode_reg == MODE_LINK)) |=> failed_reg)
        else $error("link failure did not set failed flag");

    // A command is only issued while bills remain
    a_cmd_needs_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && iss) |=> ((rem_u_reg != '0) || (rem_l_reg != '0)))
        else $error("command issued with nothing remaining");
`endif

endmodule

>>> verif/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bdt_pkg::*;

    // Predictor sizes and limits
    localparam int BUF_DEPTH = 32;
    localparam int CNT_MAX   = 4095;
    localparam int MAX_BAD_SHOWN = 10;

    // Status bytes used when building responses
    localparam logic [7:0] SB_GOOD = 8'h30;
    localparam logic [7:0] SB_STOP = 8'h31;

    // Response frame offsets
    localparam int OFS_CODE   = 0;
    localparam int OFS_EXIT_U = 3;
    localparam int OFS_STAT_S = 5;
    localparam int OFS_EXIT_L = 7;
    localparam int OFS_REJ_S  = 7;
    localparam int OFS_STAT_D = 9;
    localparam int OFS_REJ_U  = 12;
    localparam int OFS_REJ_L  = 14;

    // Status byte 0x30..0x4f to status class
    localparam logic [3:0] STATUS_CLASS [32] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd3, 4'd3, 4'd5,
        4'd6, 4'd12, 4'd7, 4'd8, 4'd7, 4'd7, 4'd12, 4'd5,
        4'd6, 4'd5, 4'd3, 4'd9, 4'd10, 4'd5, 4'd5, 4'd9,
        4'd3, 4'd5, 4'd5, 4'd12, 4'd3, 4'd12, 4'd3, 4'd12
    };

    typedef struct {
        mode_t       mode;
        logic [11:0] req_u;
        logic [11:0] req_l;
        logic [7:0]  data;
        logic        last;
    } disp_item_t;

    typedef struct {
        disp_item_t item;
        bit         fixed;
        res_t       want;
    } dir_row_t;

    typedef logic [7:0] byte_q_t [$];

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    bdt_in_if  din ();
    bdt_out_if dout ();

    bill_dispense_transaction_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (din),
        .dout      (dout),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state and configuration
    logic [11:0] rem_u, rem_l, disp_u, disp_l, rej_u, rej_l;
    bit          failed;
    logic [7:0]  fbuf [BUF_DEPTH];
    logic [5:0]  fpos;
    logic [6:0]  cfg_cap;
    logic [7:0]  cfg_up, cfg_lo, cfg_both;

    res_t     due_results [$];
    dir_row_t dir_rows [$];
    int       items_sent;
    int       results_made;
    int       n_bad;
    bit       no_idle;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(5_000_000);
        $display("** bill_dispense_transaction_top: FAILED **");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit active();
        return !failed && (rem_u != 0 || rem_l != 0);
    endfunction

    function automatic int eff_cap();
        if (cfg_cap < 7'd1)
            return 1;
        if (cfg_cap > 7'd99)
            return 99;
        return int'(cfg_cap);
    endfunction

    function automatic logic [15:0] digits(int n);
        return {8'(int'(ASCII_ZERO) + n / 10), 8'(int'(ASCII_ZERO) + n % 10)};
    endfunction

    function automatic logic [15:0] to_ascii(logic [11:0] n);
        int v;
        v = (int'(n) > eff_cap()) ? eff_cap() : int'(n);
        return digits(v);
    endfunction

    function automatic logic [11:0] sat_add(logic [11:0] a, int b);
        int s;
        s = int'(a) + b;
        return (s > CNT_MAX) ? 12'(CNT_MAX) : 12'(s);
    endfunction

    function automatic logic [11:0] sat_sub(logic [11:0] a, int b);
        return (int'(a) > b) ? 12'(int'(a) - b) : 12'd0;
    endfunction

    function automatic logic [7:0] fbyte(int i);
        return (i < BUF_DEPTH) ? fbuf[i] : 8'h00;
    endfunction

    function automatic bit is_num(logic [7:0] b);
        return b >= ASCII_ZERO && b <= ASCII_NINE;
    endfunction

    function automatic bit pair_ok(int off);
        return is_num(fbyte(off)) && is_num(fbyte(off + 1));
    endfunction

    function automatic int pair_val(int off);
        return (int'(fbyte(off)) - int'(ASCII_ZERO)) * 10
               + (int'(fbyte(off + 1)) - int'(ASCII_ZERO));
    endfunction

    function automatic logic [3:0] class_of(logic [7:0] b);
        if (b >= STAT_LO && b <= STAT_HI)
            return STATUS_CLASS[int'(b) - int'(STAT_LO)];
        return ST_UNKNOWN;
    endfunction

    function automatic res_t counters_res();
        res_t r;
        r = '0;
        r.upper_dispensed = disp_u;
        r.lower_dispensed = disp_l;
        r.upper_rejected  = rej_u;
        r.lower_rejected  = rej_l;
        return r;
    endfunction

    function automatic res_t finish_res(logic [3:0] st, logic [2:0] fe);
        res_t r;
        r = counters_res();
        r.done_res    = 1'b1;
        r.status      = st;
        r.frame_error = fe;
        return r;
    endfunction

    // Next dispense command from the remaining counts
    function automatic res_t command_res(logic [3:0] st);
        res_t r;
        r = counters_res();
        r.cmd_valid = 1'b1;
        r.status    = st;
        if (rem_u != 0 && rem_l != 0)
        begin
            r.cmd_code          = cfg_both;
            r.cmd_first_digits  = to_ascii(rem_u);
            r.cmd_second_digits = to_ascii(rem_l);
            r.cmd_data_len      = DLEN_DOUBLE;
        end
        else if (rem_u != 0)
        begin
            r.cmd_code         = cfg_up;
            r.cmd_first_digits = to_ascii(rem_u);
            r.cmd_data_len     = DLEN_SINGLE;
        end
        else
        begin
            r.cmd_code         = cfg_lo;
            r.cmd_first_digits = to_ascii(rem_l);
            r.cmd_data_len     = DLEN_SINGLE;
        end
        return r;
    endfunction

    // Check and decode a finished response frame
    function automatic res_t frame_result(logic [5:0] len);
        logic [7:0] code;
        logic [3:0] st;
        bit         up;
        code = fbyte(OFS_CODE);
        if (!active())
            return finish_res(ST_UNKNOWN, FERR_NOT_ACTIVE);
        if (len == SINGLE_FRAME_LEN)
        begin
            up = (code == cfg_up);
            if (!up && code != cfg_lo)
            begin
                failed = 1'b1;
                return finish_res(ST_UNKNOWN, FERR_UNEXP_CMD);
            end
            if (!pair_ok(OFS_EXIT_U) || !pair_ok(OFS_REJ_S))
            begin
                failed = 1'b1;
                return finish_res(ST_UNKNOWN, FERR_NON_DIGIT);
            end
            if (up)
            begin
                rem_u  = sat_sub(rem_u, pair_val(OFS_EXIT_U));
                disp_u = sat_add(disp_u, pair_val(OFS_EXIT_U));
                rej_u  = sat_add(rej_u, pair_val(OFS_REJ_S));
            end
            else
            begin
                rem_l  = sat_sub(rem_l, pair_val(OFS_EXIT_U));
                disp_l = sat_add(disp_l, pair_val(OFS_EXIT_U));
                rej_l  = sat_add(rej_l, pair_val(OFS_REJ_S));
            end
            st = class_of(fbyte(OFS_STAT_S));
        end
        else if (len == DOUBLE_FRAME_LEN)
        begin
            if (code != cfg_both)
            begin
                failed = 1'b1;
                return finish_res(ST_UNKNOWN, FERR_UNEXP_CMD);
            end
            if (!pair_ok(OFS_EXIT_U) || !pair_ok(OFS_EXIT_L) ||
                !pair_ok(OFS_REJ_U) || !pair_ok(OFS_REJ_L))
            begin
                failed = 1'b1;
                return finish_res(ST_UNKNOWN, FERR_NON_DIGIT);
            end
            rem_u  = sat_sub(rem_u, pair_val(OFS_EXIT_U));
            disp_u = sat_add(disp_u, pair_val(OFS_EXIT_U));
            rej_u  = sat_add(rej_u, pair_val(OFS_REJ_U));
            rem_l  = sat_sub(rem_l, pair_val(OFS_EXIT_L));
            disp_l = sat_add(disp_l, pair_val(OFS_EXIT_L));
            rej_l  = sat_add(rej_l, pair_val(OFS_REJ_L));
            st = class_of(fbyte(OFS_STAT_D));
        end
        else
        begin
            failed = 1'b1;
            return finish_res(ST_UNKNOWN, FERR_BAD_LEN);
        end
        if (st != ST_GOOD && st != ST_NORMAL_STOP)
        begin
            failed = 1'b1;
            return finish_res(st, FERR_NONE);
        end
        if (rem_u == 0 && rem_l == 0)
            return finish_res(st, FERR_NONE);
        return command_res(st);
    endfunction

    // One accepted item; returns 1 when it produces a result
    function automatic bit dispense_step(disp_item_t it, output res_t r);
        logic [5:0] len;
        bit         was;
        r = '0;
        case (it.mode)
            MODE_START:
            begin
                rem_u  = it.req_u;
                rem_l  = it.req_l;
                disp_u = '0;
                disp_l = '0;
                rej_u  = '0;
                rej_l  = '0;
                failed = 1'b0;
                fpos   = '0;
                if (rem_u == 0 && rem_l == 0)
                    r = finish_res(ST_REQUEST, FERR_EMPTY_REQ);
                else
                    r = command_res(ST_GOOD);
                return 1'b1;
            end
            MODE_BYTE:
            begin
                if (fpos < BUF_DEPTH)
                    fbuf[fpos] = it.data;
                if (fpos < POS_MAX)
                    fpos = fpos + 6'd1;
                if (!it.last)
                    return 1'b0;
                len  = fpos;
                fpos = '0;
                r = frame_result(len);
                return 1'b1;
            end
            MODE_LINK:
            begin
                was    = active();
                failed = 1'b1;
                fpos   = '0;
                r = finish_res(ST_CONNECTION, was ? FERR_NONE : FERR_NOT_ACTIVE);
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic disp_item_t mk_item(mode_t m, logic [11:0] u, logic [11:0] l,
                                           logic [7:0] d, logic last);
        disp_item_t it;
        it.mode  = m;
        it.req_u = u;
        it.req_l = l;
        it.data  = d;
        it.last  = last;
        return it;
    endfunction

    function automatic disp_item_t rnd_item(mode_t m);
        return mk_item(m, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                       8'($urandom_range(255)), 1'($urandom_range(1)));
    endfunction

    function automatic res_t lit_done(logic [3:0] st, logic [2:0] fe);
        res_t r;
        r = '0;
        r.done_res    = 1'b1;
        r.status      = st;
        r.frame_error = fe;
        return r;
    endfunction

    function automatic res_t lit_cmd(logic [7:0] code, logic [15:0] d1, logic [15:0] d2,
                                     logic [2:0] dlen);
        res_t r;
        r = '0;
        r.cmd_valid         = 1'b1;
        r.cmd_code          = code;
        r.cmd_first_digits  = d1;
        r.cmd_second_digits = d2;
        r.cmd_data_len      = dlen;
        return r;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(disp_item_t it, bit fixed, res_t want);
        dir_row_t row;
        row.item  = it;
        row.fixed = fixed;
        row.want  = want;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void put_pair(ref byte_q_t fr, input int at, input int n);
        logic [15:0] d;
        d = digits(n);
        fr[at]     = d[15:8];
        fr[at + 1] = d[7:0];
    endfunction

    function automatic int exit_pick(logic [11:0] rem);
        int sent;
        int p;
        sent = (int'(rem) > eff_cap()) ? eff_cap() : int'(rem);
        p = $urandom_range(99);
        if (p < 55)
            return sent;
        if (p < 85)
            return $urandom_range(sent, 0);
        return $urandom_range(99);
    endfunction

    function automatic int reject_pick();
        int p;
        p = $urandom_range(99);
        if (p < 70)
            return 0;
        if (p < 90)
            return $urandom_range(5);
        return $urandom_range(99);
    endfunction

    function automatic logic [7:0] status_pick();
        int p;
        p = $urandom_range(99);
        if (p < 75)
            return $urandom_range(1) ? SB_GOOD : SB_STOP;
        if (p < 92)
            return 8'($urandom_range(STAT_HI, STAT_LO));
        return 8'($urandom_range(255));
    endfunction

    // Response to the command the block has just issued, optionally damaged
    function automatic byte_q_t build_frame(bit clean);
        byte_q_t    fr;
        bit         both;
        int         len;
        int         k;
        int         at;
        logic [7:0] b;
        both = (rem_u != 0) && (rem_l != 0);
        len  = both ? int'(DOUBLE_FRAME_LEN) : int'(SINGLE_FRAME_LEN);
        for (k = 0; k < len; k++)
            fr.insert(fr.size(), 8'($urandom_range(255)));
        if (both)
        begin
            fr[OFS_CODE] = cfg_both;
            put_pair(fr, OFS_EXIT_U, exit_pick(rem_u));
            put_pair(fr, OFS_EXIT_L, exit_pick(rem_l));
            fr[OFS_STAT_D] = status_pick();
            put_pair(fr, OFS_REJ_U, reject_pick());
            put_pair(fr, OFS_REJ_L, reject_pick());
        end
        else
        begin
            fr[OFS_CODE] = (rem_u != 0) ? cfg_up : cfg_lo;
            put_pair(fr, OFS_EXIT_U, exit_pick((rem_u != 0) ? rem_u : rem_l));
            fr[OFS_STAT_S] = status_pick();
            put_pair(fr, OFS_REJ_S, reject_pick());
        end
        if (!clean)
        begin
            case ($urandom_range(3))
                0: fr[OFS_CODE] = 8'($urandom_range(255));
                1:
                begin
                    // one count digit replaced by a non-digit
                    at = both ? OFS_REJ_L + $urandom_range(1) : OFS_REJ_S + $urandom_range(1);
                    if ($urandom_range(1))
                        at = OFS_EXIT_U + $urandom_range(1);
                    b = 8'($urandom_range(255));
                    if (is_num(b))
                        b = b ^ 8'h40;
                    fr[at] = b;
                end
                2:
                begin
                    // wrong length, up to past the position limit
                    k = $urandom_range(70, 1);
                    if (k == len)
                        k = k + 1;
                    while (fr.size() > k)
                        void'(fr.pop_back());
                    while (fr.size() < k)
                        fr.insert(fr.size(), 8'($urandom_range(255)));
                end
                default: fr[both ? OFS_STAT_D : OFS_STAT_S] = 8'($urandom_range(255));
            endcase
        end
        return fr;
    endfunction

    function automatic string show_res(res_t r);
        return $sformatf({"cmd=%0b code=%02h d1=%04h d2=%04h len=%0d done=%0b st=%0d ",
                          "du=%0d dl=%0d ru=%0d rl=%0d fe=%0d"},
                         r.cmd_valid, r.cmd_code, r.cmd_first_digits, r.cmd_second_digits,
                         r.cmd_data_len, r.done_res, r.status, r.upper_dispensed,
                         r.lower_dispensed, r.upper_rejected, r.lower_rejected,
                         r.frame_error);
    endfunction

    // ---------------------------------------------------------------- drivers

    // Present one item, wait for it to be taken, then maybe idle
    task automatic send(disp_item_t it, bit fixed, res_t lit);
        res_t r;
        bit   got;
        din.valid         <= 1'b1;
        din.mode          <= it.mode;
        din.request_upper <= it.req_u;
        din.request_lower <= it.req_l;
        din.data_byte     <= it.data;
        din.last_byte     <= it.last;
        do
            @(posedge clk);
        while (din.ready !== 1'b1);
        got = dispense_step(it, r);
        if (got)
        begin
            due_results.insert(due_results.size(), fixed ? lit : r);
            results_made++;
        end
        items_sent++;
        // each idle cycle drawn on its own, about 35 in a hundred overall
        while (!no_idle && $urandom_range(99) < 35)
        begin
            din.valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_frame(byte_q_t fr);
        int i;
        for (i = 0; i < fr.size(); i++)
            send(mk_item(MODE_BYTE, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                         fr[i], i == fr.size() - 1), 1'b0, '0);
    endtask

    // Hold the sender until every result is back and the pipe is empty
    task automatic settle();
        din.valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_regs(logic [7:0] cap, logic [7:0] cu, logic [7:0] cl,
                             logic [7:0] cb);
        logic [7:0] vals [4];
        int         i;
        vals = '{cap, cu, cl, cb};
        for (i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            case (cfg_idx_t'(i))
                CFG_MAX_PER_CMD: cfg_cap  = vals[i][6:0];
                CFG_CODE_UPPER:  cfg_up   = vals[i];
                CFG_CODE_LOWER:  cfg_lo   = vals[i];
                default:         cfg_both = vals[i];
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    // A start followed by responses to the commands it leads to
    task automatic run_op();
        logic [11:0] ru, rl;
        int          p;
        int          k;
        int          limit;
        p = $urandom_range(99);
        if (p < 60)
        begin
            ru = 12'($urandom_range(150));
            rl = 12'($urandom_range(150));
        end
        else if (p < 85)
        begin
            ru = 12'($urandom_range(999));
            rl = 12'($urandom_range(999));
        end
        else
        begin
            ru = 12'($urandom_range(4095));
            rl = 12'($urandom_range(4095));
        end
        if (p < 3)
        begin
            ru = '0;
            rl = '0;
        end
        else if ($urandom_range(3) == 0)
        begin
            if ($urandom_range(1))
                ru = '0;
            else
                rl = '0;
        end
        send(mk_item(MODE_START, ru, rl, 8'($urandom_range(255)), 1'($urandom_range(1))),
             1'b0, '0);
        limit = $urandom_range(10, 1);
        for (k = 0; k < limit && active(); k++)
        begin
            p = $urandom_range(99);
            if (p < 4)
                send(rnd_item(MODE_LINK), 1'b0, '0);
            else if (p < 7)
                send(rnd_item(MODE_NONE), 1'b0, '0);
            else
                send_frame(build_frame($urandom_range(99) >= 8));
        end
        // one more frame, which may come after completion or failure
        if ($urandom_range(99) < 8)
            send_frame(build_frame(1'b1));
    endtask

    task automatic random_phase(int n_items, int n_res);
        int item_goal;
        int res_goal;
        int k;
        bit paused;
        item_goal = items_sent + n_items;
        res_goal  = results_made + n_res;
        paused    = 1'b0;
        while (items_sent < item_goal || results_made < res_goal)
        begin
            if (!paused && items_sent >= item_goal - n_items / 2)
            begin
                settle();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 80)
                run_op();
            else
                for (k = $urandom_range(6, 1); k > 0; k--)
                    send(rnd_item(mode_t'($urandom_range(3))), 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------- result checker

    always @(posedge clk)
    begin
        res_t seen;
        res_t want;
        if (rst_n === 1'b1 && dout.valid === 1'b1 && dout.ready === 1'b1)
        begin
            seen = {dout.cmd_valid, dout.cmd_code, dout.cmd_first_digits,
                    dout.cmd_second_digits, dout.cmd_data_len, dout.done_res, dout.status,
                    dout.upper_dispensed, dout.lower_dispensed, dout.upper_rejected,
                    dout.lower_rejected, dout.frame_error};
            if (due_results.size() == 0)
            begin
                n_bad++;
                if (n_bad <= MAX_BAD_SHOWN)
                    $display("unexpected result: %s", show_res(seen));
            end
            else
            begin
                want = due_results.pop_front();
                if (seen !== want)
                begin
                    n_bad++;
                    if (n_bad <= MAX_BAD_SHOWN)
                        $display("mismatch\n  expected %s\n  actual   %s",
                                 show_res(want), show_res(seen));
                end
            end
        end
    end

    // Output stalls
    initial
    begin
        dout.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            dout.ready <= no_idle || ($urandom_range(99) >= 35);
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial
    begin
        dir_row_t    row;
        logic [7:0]  dir_frame [10];
        int          i;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_MAX_PER_CMD;
        cfg_data          <= 8'h00;
        din.valid         <= 1'b0;
        din.mode          <= MODE_NONE;
        din.request_upper <= '0;
        din.request_lower <= '0;
        din.data_byte     <= '0;
        din.last_byte     <= 1'b0;

        rem_u = '0; rem_l = '0; disp_u = '0; disp_l = '0; rej_u = '0; rej_l = '0;
        failed = 1'b0;
        fpos = '0;
        for (i = 0; i < BUF_DEPTH; i++)
            fbuf[i] = 8'h00;
        cfg_cap  = MAX_PER_CMD_RST;
        cfg_up   = CODE_UPPER_RST;
        cfg_lo   = CODE_LOWER_RST;
        cfg_both = CODE_BOTH_RST;
        items_sent = 0;
        results_made = 0;
        n_bad = 0;
        no_idle = 1'b0;

        // Directed rows, reset configuration
        add_row(rnd_item(MODE_LINK), 1'b1, lit_done(ST_CONNECTION, FERR_NOT_ACTIVE));
        add_row(mk_item(MODE_BYTE, 12'h000, 12'h000, 8'hff, 1'b1), 1'b1,
                lit_done(ST_UNKNOWN, FERR_NOT_ACTIVE));
        add_row(mk_item(MODE_START, 12'h000, 12'h000, 8'h00, 1'b0), 1'b1,
                lit_done(ST_REQUEST, FERR_EMPTY_REQ));
        add_row(mk_item(MODE_NONE, 12'hfff, 12'hfff, 8'hff, 1'b1), 1'b0, '0);
        add_row(mk_item(MODE_START, 12'hfff, 12'hfff, 8'hff, 1'b1), 1'b1,
                lit_cmd(CODE_BOTH_RST, 16'h3630, 16'h3630, DLEN_DOUBLE));
        // two-byte frame: bad length
        add_row(mk_item(MODE_BYTE, 12'hfff, 12'h000, 8'h00, 1'b0), 1'b0, '0);
        add_row(mk_item(MODE_BYTE, 12'h000, 12'hfff, CODE_BOTH_RST, 1'b1), 1'b1,
                lit_done(ST_UNKNOWN, FERR_BAD_LEN));
        add_row(mk_item(MODE_START, 12'h001, 12'h000, 8'h00, 1'b0), 1'b1,
                lit_cmd(CODE_UPPER_RST, 16'h3031, 16'h0000, DLEN_SINGLE));
        // one bill out, good status: operation completes
        dir_frame = '{CODE_UPPER_RST, 8'h00, 8'hff, ASCII_ZERO, 8'h31, SB_GOOD,
                      8'h00, ASCII_ZERO, ASCII_ZERO, 8'hff};
        for (i = 0; i < 10; i++)
            add_row(mk_item(MODE_BYTE, 12'h000, 12'h000, dir_frame[i], i == 9), 1'b0, '0);
        add_row(rnd_item(MODE_LINK), 1'b0, '0);
        add_row(mk_item(MODE_START, 12'h000, 12'hfff, 8'h00, 1'b0), 1'b1,
                lit_cmd(CODE_LOWER_RST, 16'h3630, 16'h0000, DLEN_SINGLE));
        add_row(rnd_item(MODE_LINK), 1'b1, lit_done(ST_CONNECTION, FERR_NONE));
        add_row(mk_item(MODE_START, 12'h800, 12'h001, 8'h00, 1'b0), 1'b0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[j])
        begin
            row = dir_rows[j];
            send(row.item, row.fixed, row.want);
        end

        // Random phases, each under its own register setting
        settle();
        load_regs(MAX_PER_CMD_RST, CODE_UPPER_RST, CODE_LOWER_RST, CODE_BOTH_RST);
        random_phase(55, 8);

        settle();
        load_regs(8'd99, 8'h00, 8'hff, 8'h80);
        random_phase(55, 8);

        // no idling on either side through this phase; cap of zero acts as one
        settle();
        load_regs(8'd0, 8'hff, 8'h00, 8'h7f);
        no_idle = 1'b1;
        random_phase(55, 8);
        no_idle = 1'b0;

        // cap above 99, upper and lower codes equal
        settle();
        load_regs(8'd127, 8'h41, 8'h41, 8'h42);
        random_phase(55, 8);

        settle();
        load_regs(8'($urandom_range(99, 1)), 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
        random_phase(55, 8);

        settle();
        repeat (8) @(posedge clk);
        if (n_bad == 0)
            $display("** bill_dispense_transaction_top: PASSED **");
        else
            $display("** bill_dispense_transaction_top: FAILED **");
        $finish;
    end

endmodule

>>> bill_dispense_transaction_top.f
hdl/bdt_pkg.sv
hdl/bdt_in_if.sv
hdl/bdt_out_if.sv
hdl/bdt_frame_capture.sv
hdl/bill_dispense_transaction_top.sv
verif/testbench.sv
